[hdl/turtle_graphics_interpreter_macros.svh]
// Assertion helpers for the turtle interpreter.
`ifndef TURTLE_GRAPHICS_INTERPRETER_MACROS_SVH
`define TURTLE_GRAPHICS_INTERPRETER_MACROS_SVH

`ifndef SYNTHESIS
`define TGI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("turtle_graphics_interpreter: assertion failed");
`define TGI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("turtle_graphics_interpreter: assertion failed");
`else
`define TGI_ASSERT(lbl, prop)
`define TGI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/tgi_pkg.sv]
package tgi_pkg;

  typedef enum logic [2:0] {
    OP_BEGIN,
    OP_LEFT,
    OP_RIGHT,
    OP_FWD,
    OP_PUSH,
    OP_POP
  } op_e;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_POINT     = 2'd0;
  localparam logic [1:0] KIND_SEPARATOR = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW  = 2'd2;
  localparam logic [1:0] KIND_UNDERFLOW = 2'd3;

  localparam logic [1:0] CFG_TURN_STEP     = 2'd0;
  localparam logic [1:0] CFG_START_HEADING = 2'd1;
  localparam logic [1:0] CFG_START_X       = 2'd2;
  localparam logic [1:0] CFG_START_Y       = 2'd3;

  localparam logic [6:0] HEADINGS      = 7'd72;
  localparam logic [6:0] HEADING_RESET = 7'd5;

  typedef struct packed {
    logic [6:0]  turn_step;
    logic [6:0]  start_heading;
    logic [31:0] start_x;
    logic [31:0] start_y;
  } cfg_t;

  // cos(5k deg), k = 0..18, with 24 fraction bits
  function automatic logic [24:0] cos_rom(input logic [4:0] idx);
    logic [24:0] v;
    case (idx)
      5'd0:    v = 25'd16777216;
      5'd1:    v = 25'd16713374;
      5'd2:    v = 25'd16522332;
      5'd3:    v = 25'd16205546;
      5'd4:    v = 25'd15765426;
      5'd5:    v = 25'd15205322;
      5'd6:    v = 25'd14529495;
      5'd7:    v = 25'd13743091;
      5'd8:    v = 25'd12852093;
      5'd9:    v = 25'd11863283;
      5'd10:   v = 25'd10784187;
      5'd11:   v = 25'd9623016;
      5'd12:   v = 25'd8388608;
      5'd13:   v = 25'd7090358;
      5'd14:   v = 25'd5738146;
      5'd15:   v = 25'd4342263;
      5'd16:   v = 25'd2913333;
      5'd17:   v = 25'd1462231;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/tgi_ram.sv]
module tgi_ram #(
  parameter int WIDTH = 71,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/tgi_front.sv]
module tgi_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            action_i,
  input  logic [7:0]      symbol_i,
  output logic            op_valid_o,
  output tgi_pkg::op_e    op_o,
  input  logic            op_ready_i
);

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_FWD   = 8'h46;
  localparam logic [7:0] SYM_PUSH  = 8'h5B;
  localparam logic [7:0] SYM_POP   = 8'h5D;

  logic         op_valid_q, op_valid_d;
  tgi_pkg::op_e op_q, op_d;
  tgi_pkg::op_e dec_op;
  logic         dec_known;
  logic         accept;

  always_comb begin
    dec_op    = tgi_pkg::OP_BEGIN;
    dec_known = 1'b1;
    if (action_i) begin
      unique case (symbol_i)
        SYM_PLUS:  dec_op = tgi_pkg::OP_LEFT;
        SYM_MINUS: dec_op = tgi_pkg::OP_RIGHT;
        SYM_FWD:   dec_op = tgi_pkg::OP_FWD;
        SYM_PUSH:  dec_op = tgi_pkg::OP_PUSH;
        SYM_POP:   dec_op = tgi_pkg::OP_POP;
        default:   dec_known = 1'b0;
      endcase
    end
  end

  assign in_ready_o = !op_valid_q || op_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // unknown symbols are taken and dropped here
  always_comb begin
    op_valid_d = op_valid_q && !op_ready_i;
    op_d       = op_q;
    if (accept) begin
      op_valid_d = dec_known;
      op_d       = dec_op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
      op_q       <= tgi_pkg::OP_BEGIN;
    end else begin
      op_valid_q <= op_valid_d;
      op_q       <= op_d;
    end
  end

  assign op_valid_o = op_valid_q;
  assign op_o       = op_q;

endmodule

[hdl/tgi_queue.sv]
module tgi_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  tgi_pkg::op_e push_op_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output tgi_pkg::op_e pop_op_o
);

  localparam int PW = $clog2(tgi_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(tgi_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(tgi_pkg::QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(tgi_pkg::QUEUE_DEPTH - 1);

  tgi_pkg::op_e  entry_q [tgi_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign push_ready_o = (count_q != FULL);
  assign pop_valid_o  = (count_q != '0);
  assign pop_op_o     = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

[hdl/tgi_back.sv]
module tgi_back #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tgi_pkg::cfg_t cfg_i,
  input  logic          op_valid_i,
  input  tgi_pkg::op_e  op_i,
  output logic          op_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [31:0]   pos_x_o,
  output logic [31:0]   pos_y_o,
  output logic          last_o
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int SHIFT = 24 - FRAC_BITS;
  localparam int MAG_W = FRAC_BITS + 1;
  localparam logic [25:0]   ROUND = (26'(1) << SHIFT) >> 1;
  localparam logic [CW-1:0] FULL  = CW'(STACK_DEPTH);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [6:0]  heading;
  } entry_t;

  typedef struct packed {
    logic       neg;
    logic [4:0] idx;
  } trig_t;

  // quarter-wave folding of a heading onto the ROM
  function automatic trig_t trig_of(input logic [6:0] h);
    trig_t t;
    if (h <= 7'd18) begin
      t.neg = 1'b0;
      t.idx = h[4:0];
    end else if (h <= 7'd36) begin
      t.neg = 1'b1;
      t.idx = 5'(7'd36 - h);
    end else if (h <= 7'd54) begin
      t.neg = 1'b1;
      t.idx = 5'(h - 7'd36);
    end else begin
      t.neg = 1'b0;
      t.idx = 5'(tgi_pkg::HEADINGS - h);
    end
    return t;
  endfunction

  function automatic logic [32:0] delta_of(input logic [6:0] h);
    trig_t            t;
    logic [25:0]      r;
    logic [MAG_W-1:0] m;
    logic [32:0]      e;
    t = trig_of(h);
    r = {1'b0, tgi_pkg::cos_rom(t.idx)} + ROUND;
    m = MAG_W'(r >> SHIFT);
    e = 33'(m);
    return t.neg ? (~e + 33'd1) : e;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] d);
    logic [32:0] s;
    s = {a[31], a} + d;
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  logic [31:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [6:0]    heading_q, heading_d;
  logic [CW-1:0] count_q, count_d;
  logic          pop_phase_q, pop_phase_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    kind_q;
  logic [31:0]   out_x_q, out_y_q;
  logic          last_q;

  logic          slot;
  logic          emit;
  logic [1:0]    emit_kind;
  logic [31:0]   emit_x, emit_y;
  logic          emit_last;
  logic [6:0]    step, start_h, sin_h;
  logic [7:0]    h_sum, h_sub;
  logic [6:0]    h_plus, h_minus;
  logic [CW-1:0] count_m1;
  logic [31:0]   fwd_x, fwd_y;
  logic          ram_wr, ram_rd;
  entry_t        ram_wdata, ram_rdata;

  assign step    = (cfg_i.turn_step >= tgi_pkg::HEADINGS) ?
                   cfg_i.turn_step - tgi_pkg::HEADINGS : cfg_i.turn_step;
  assign start_h = (cfg_i.start_heading >= tgi_pkg::HEADINGS) ?
                   cfg_i.start_heading - tgi_pkg::HEADINGS : cfg_i.start_heading;

  assign h_sum   = {1'b0, heading_q} + {1'b0, step};
  assign h_plus  = (h_sum >= {1'b0, tgi_pkg::HEADINGS}) ?
                   7'(h_sum - {1'b0, tgi_pkg::HEADINGS}) : h_sum[6:0];
  assign h_sub   = {1'b0, heading_q} + {1'b0, tgi_pkg::HEADINGS} - {1'b0, step};
  assign h_minus = (heading_q >= step) ? heading_q - step : h_sub[6:0];

  // sine is cosine a quarter turn back: heading + 54 mod 72
  assign sin_h = (heading_q < 7'd18) ? heading_q + 7'd54 : heading_q - 7'd18;
  assign fwd_x = sat_add(pos_x_q, delta_of(heading_q));
  assign fwd_y = sat_add(pos_y_q, delta_of(sin_h));

  assign count_m1  = count_q - 1'b1;
  assign ram_wdata = '{x: pos_x_q, y: pos_y_q, heading: heading_q};
  assign slot      = !out_valid_q || out_ready_i;

  tgi_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_rd),
    .rd_addr_i (count_m1[AW-1:0]),
    .rd_data_o (ram_rdata)
  );

  always_comb begin
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    heading_d   = heading_q;
    count_d     = count_q;
    pop_phase_d = pop_phase_q;
    op_ready_o  = 1'b0;
    ram_wr      = 1'b0;
    ram_rd      = 1'b0;
    emit        = 1'b0;
    emit_kind   = tgi_pkg::KIND_POINT;
    emit_x      = '0;
    emit_y      = '0;
    emit_last   = 1'b1;

    if (pop_phase_q) begin
      // second half of a pop: restored pose from the stack read
      if (slot) begin
        pos_x_d     = ram_rdata.x;
        pos_y_d     = ram_rdata.y;
        heading_d   = ram_rdata.heading;
        pop_phase_d = 1'b0;
        emit        = 1'b1;
        emit_x      = ram_rdata.x;
        emit_y      = ram_rdata.y;
      end
    end else if (op_valid_i) begin
      unique case (op_i)
        tgi_pkg::OP_BEGIN: begin
          if (slot) begin
            op_ready_o = 1'b1;
            pos_x_d    = cfg_i.start_x;
            pos_y_d    = cfg_i.start_y;
            heading_d  = start_h;
            count_d    = '0;
            emit       = 1'b1;
            emit_x     = cfg_i.start_x;
            emit_y     = cfg_i.start_y;
          end
        end
        tgi_pkg::OP_LEFT: begin
          op_ready_o = 1'b1;
          heading_d  = h_minus;
        end
        tgi_pkg::OP_RIGHT: begin
          op_ready_o = 1'b1;
          heading_d  = h_plus;
        end
        tgi_pkg::OP_FWD: begin
          if (slot) begin
            op_ready_o = 1'b1;
            pos_x_d    = fwd_x;
            pos_y_d    = fwd_y;
            emit       = 1'b1;
            emit_x     = fwd_x;
            emit_y     = fwd_y;
          end
        end
        tgi_pkg::OP_PUSH: begin
          if (count_q == FULL) begin
            if (slot) begin
              op_ready_o = 1'b1;
              emit       = 1'b1;
              emit_kind  = tgi_pkg::KIND_OVERFLOW;
            end
          end else begin
            op_ready_o = 1'b1;
            ram_wr     = 1'b1;
            count_d    = count_q + 1'b1;
          end
        end
        tgi_pkg::OP_POP: begin
          if (slot) begin
            op_ready_o = 1'b1;
            emit       = 1'b1;
            if (count_q == '0) begin
              emit_kind = tgi_pkg::KIND_UNDERFLOW;
            end else begin
              ram_rd      = 1'b1;
              count_d     = count_m1;
              pop_phase_d = 1'b1;
              emit_kind   = tgi_pkg::KIND_SEPARATOR;
              emit_last   = 1'b0;
            end
          end
        end
        default: op_ready_o = 1'b1;
      endcase
    end

    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= tgi_pkg::HEADING_RESET;
      count_q     <= '0;
      pop_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
      count_q     <= count_d;
      pop_phase_q <= pop_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= emit_kind;
      out_x_q <= emit_x;
      out_y_q <= emit_y;
      last_q  <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign last_o      = last_q;

endmodule

[hdl/turtle_graphics_interpreter.sv]
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | action_i, symbol_i
// out     | output    | out_valid_o/out_ready_i| kind_o, pos_x_out_o, pos_y_out_o, last_o
// cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One symbol per cycle while the output is not stalled and no ']' is executing; ']' holds
// the executor for a separator, then the point restored from the registered stack RAM read.
// An input transaction passes the classify register, the queue and the output register.
// Unknown symbols are dropped at the front.
// Reset: pose (0, 0) heading 5, empty stack; stack RAM contents are not cleared.
// An output stall fills the 4-entry queue and the classify register, then in_ready_o drops.
`include "turtle_graphics_interpreter_macros.svh"

module turtle_graphics_interpreter #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] pos_x_out_o,
  output logic [31:0] pos_y_out_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  tgi_pkg::cfg_t cfg_q, cfg_d;
  logic          fr_valid, fr_ready;
  tgi_pkg::op_e  fr_op;
  logic          qu_valid, qu_ready;
  tgi_pkg::op_e  qu_op;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tgi_pkg::CFG_TURN_STEP:     cfg_d.turn_step     = cfg_data_i[6:0];
        tgi_pkg::CFG_START_HEADING: cfg_d.start_heading = cfg_data_i[6:0];
        tgi_pkg::CFG_START_X:       cfg_d.start_x       = cfg_data_i;
        tgi_pkg::CFG_START_Y:       cfg_d.start_y       = cfg_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{turn_step:     tgi_pkg::HEADING_RESET,
                 start_heading: tgi_pkg::HEADING_RESET,
                 start_x:       32'd0,
                 start_y:       32'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tgi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .symbol_i   (symbol_i),
    .op_valid_o (fr_valid),
    .op_o       (fr_op),
    .op_ready_i (fr_ready)
  );

  tgi_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_op_i    (fr_op),
    .pop_valid_o  (qu_valid),
    .pop_ready_i  (qu_ready),
    .pop_op_o     (qu_op)
  );

  tgi_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (qu_valid),
    .op_i        (qu_op),
    .op_ready_o  (qu_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .pos_x_o     (pos_x_out_o),
    .pos_y_o     (pos_y_out_o),
    .last_o      (last_o)
  );

  // a separator is always followed directly by the restored point
  `TGI_ASSERT_NEXT(a_sep_then_point,
    out_valid_o && out_ready_i && kind_o == tgi_pkg::KIND_SEPARATOR,
    out_valid_o && kind_o == tgi_pkg::KIND_POINT && last_o)
  `TGI_ASSERT(a_only_sep_not_last,
    (out_valid_o && !last_o) |-> (kind_o == tgi_pkg::KIND_SEPARATOR))
  `TGI_ASSERT(a_non_point_zero,
    (out_valid_o && kind_o != tgi_pkg::KIND_POINT) |->
      (pos_x_out_o == 32'd0 && pos_y_out_o == 32'd0))

endmodule

[sim/tb.sv]
module tb;

  localparam int STACK_DEPTH = 64;
  localparam int FRAC_BITS   = 16;
  localparam int ROM_SHIFT   = 24 - FRAC_BITS;
  localparam int COMPASS     = 72;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 250;

  localparam logic ACT_BEGIN  = 1'b0;
  localparam logic ACT_SYMBOL = 1'b1;

  localparam logic [7:0] SYM_TURN_NEG = 8'h2B; // '+'
  localparam logic [7:0] SYM_TURN_POS = 8'h2D; // '-'
  localparam logic [7:0] SYM_FWD      = 8'h46; // 'F'
  localparam logic [7:0] SYM_PUSH     = 8'h5B; // '['
  localparam logic [7:0] SYM_POP      = 8'h5D; // ']'

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  // quarter-wave cosine, 24 fraction bits
  localparam int unsigned COS_TAB [19] = '{
    16777216, 16713374, 16522332, 16205546, 15765426,
    15205322, 14529495, 13743091, 12852093, 11863283,
    10784187, 9623016, 8388608, 7090358, 5738146,
    4342263, 2913333, 1462231, 0
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic        fin;
  } mark_t;

  typedef struct {
    bit          cfg;
    logic [1:0]  idx;
    logic [31:0] data;
    logic        act;
    logic [7:0]  sym;
    int          reps;
    bit          pinned;
    mark_t       pin;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_action = 1'b0;
  logic [7:0]  in_symbol = 8'h00;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = tgi_pkg::CFG_TURN_STEP;
  logic [31:0] cfg_data = 32'h0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [31:0] pos_x_out_o;
  logic [31:0] pos_y_out_o;
  logic        last_o;
  logic        cfg_ready_o;

  turtle_graphics_interpreter #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .action_i   (in_action),
    .symbol_i   (in_symbol),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .kind_o     (kind_o),
    .pos_x_out_o(pos_x_out_o),
    .pos_y_out_o(pos_y_out_o),
    .last_o     (last_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #4 clk = ~clk;

  // turtle pose, pose stack and register copies
  int          set_turn, set_heading;
  logic [31:0] set_x, set_y;
  logic [31:0] pen_x, pen_y;
  int          pen_heading;
  int          depth;
  logic [31:0] saved_x [STACK_DEPTH];
  logic [31:0] saved_y [STACK_DEPTH];
  int          saved_heading [STACK_DEPTH];

  mark_t marks_due [$];
  int    mismatches = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    hold_left = 0;
  bit    settled = 1'b1;

  task automatic complain(input string what);
    mismatches++;
    if (mismatches <= 50)
      $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic longint rom_step(input int unsigned mag);
    return longint'((mag + (32'd1 << (ROM_SHIFT - 1))) >> ROM_SHIFT);
  endfunction

  function automatic longint cos_of(input int h);
    int a;
    a = h % COMPASS;
    if (a <= 18) return rom_step(COS_TAB[a]);
    if (a <= 36) return -rom_step(COS_TAB[36 - a]);
    if (a <= 54) return -rom_step(COS_TAB[a - 36]);
    return rom_step(COS_TAB[72 - a]);
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input longint d);
    longint r;
    r = longint'($signed(a)) + d;
    if (r > POS_MAX) r = POS_MAX;
    if (r < POS_MIN) r = POS_MIN;
    return r[31:0];
  endfunction

  task automatic step_turtle(input logic act, input logic [7:0] sym,
                             output mark_t m0, output mark_t m1, output int n);
    int step;
    step = set_turn % COMPASS;
    n = 0;
    m0 = '0;
    m1 = '0;
    if (act == ACT_BEGIN) begin
      pen_x = set_x;
      pen_y = set_y;
      pen_heading = set_heading % COMPASS;
      depth = 0;
      m0 = '{kind: tgi_pkg::KIND_POINT, x: pen_x, y: pen_y, fin: 1'b1};
      n = 1;
    end else begin
      case (sym)
        SYM_TURN_NEG: pen_heading = (pen_heading + COMPASS - step) % COMPASS;
        SYM_TURN_POS: pen_heading = (pen_heading + step) % COMPASS;
        SYM_FWD: begin
          pen_x = sat_add(pen_x, cos_of(pen_heading));
          pen_y = sat_add(pen_y, cos_of(pen_heading + 54));
          m0 = '{kind: tgi_pkg::KIND_POINT, x: pen_x, y: pen_y, fin: 1'b1};
          n = 1;
        end
        SYM_PUSH: begin
          if (depth >= STACK_DEPTH) begin
            m0 = '{kind: tgi_pkg::KIND_OVERFLOW, x: 32'h0, y: 32'h0, fin: 1'b1};
            n = 1;
          end else begin
            saved_x[depth] = pen_x;
            saved_y[depth] = pen_y;
            saved_heading[depth] = pen_heading;
            depth++;
          end
        end
        SYM_POP: begin
          if (depth == 0) begin
            m0 = '{kind: tgi_pkg::KIND_UNDERFLOW, x: 32'h0, y: 32'h0, fin: 1'b1};
            n = 1;
          end else begin
            depth--;
            pen_x = saved_x[depth];
            pen_y = saved_y[depth];
            pen_heading = saved_heading[depth] % COMPASS;
            m0 = '{kind: tgi_pkg::KIND_SEPARATOR, x: 32'h0, y: 32'h0, fin: 1'b0};
            m1 = '{kind: tgi_pkg::KIND_POINT, x: pen_x, y: pen_y, fin: 1'b1};
            n = 2;
          end
        end
        default: ;
      endcase
    end
  endtask

  // entered and left at a falling edge; valid stays up for a following item
  task automatic send_item(input logic act, input logic [7:0] sym,
                           input bit pinned = 1'b0, input mark_t pin = '0);
    mark_t m0, m1;
    int    n;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_symbol <= sym;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    step_turtle(act, sym, m0, m1, n);
    if (pinned) begin
      marks_due.push_back(pin);
    end else begin
      if (n > 0) marks_due.push_back(m0);
      if (n > 1) marks_due.push_back(m1);
    end
    settled = 1'b0;
    @(negedge clk);
  endtask

  // idle the input, let every result out, then give no-result items time to clear
  task automatic drain();
    in_valid <= 1'b0;
    while (marks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    settled = 1'b1;
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      tgi_pkg::CFG_TURN_STEP:     set_turn = int'(data[6:0]);
      tgi_pkg::CFG_START_HEADING: set_heading = int'(data[6:0]);
      tgi_pkg::CFG_START_X:       set_x = data;
      tgi_pkg::CFG_START_Y:       set_y = data;
      default: ;
    endcase
    @(negedge clk);
    if (!more) cfg_valid <= 1'b0;
  endtask

  function automatic row_t sym_row(input logic act, input logic [7:0] sym, input int reps = 1);
    row_t r;
    r = '{cfg: 1'b0, idx: tgi_pkg::CFG_TURN_STEP, data: 32'h0, act: act, sym: sym,
          reps: reps, pinned: 1'b0, pin: '0};
    return r;
  endfunction

  function automatic row_t pin_row(input logic act, input logic [7:0] sym,
                                   input logic [1:0] kind, input logic [31:0] x,
                                   input logic [31:0] y);
    row_t r;
    r = sym_row(act, sym);
    r.pinned = 1'b1;
    r.pin = '{kind: kind, x: x, y: y, fin: 1'b1};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [1:0] idx, input logic [31:0] data);
    row_t r;
    r = sym_row(ACT_SYMBOL, 8'h00);
    r.cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [31:0] pick_angle();
    logic [6:0] a;
    case ($urandom_range(3))
      0:       a = 7'd0;
      1:       a = 7'd71;
      2:       a = 7'd127;
      default: a = 7'($urandom_range(127));
    endcase
    return {25'($urandom() >> 7), a};
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return {{8{v[23]}}, v[23:0]};
      default: return v;
    endcase
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    mark_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (marks_due.size() == 0) begin
        complain($sformatf("unexpected result: kind %0d x %h y %h last %b",
                           kind_o, pos_x_out_o, pos_y_out_o, last_o));
      end else begin
        want = marks_due.pop_front();
        if (kind_o !== want.kind)
          complain($sformatf("kind %0d, expected %0d", kind_o, want.kind));
        if (pos_x_out_o !== want.x)
          complain($sformatf("pos_x %h, expected %h", pos_x_out_o, want.x));
        if (pos_y_out_o !== want.y)
          complain($sformatf("pos_y %h, expected %h", pos_y_out_o, want.y));
        if (last_o !== want.fin)
          complain($sformatf("last %b, expected %b", last_o, want.fin));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("turtle_graphics_interpreter: mismatch");
    $finish;
  end

  initial begin
    row_t plan [$];
    int   send_idle [5];
    int   recv_stall [5];
    int   sent;
    int   r;
    logic [7:0] noise;

    send_idle  = '{0, 68, 0, 25, 0};
    recv_stall = '{0, 0, 68, 25, 0};

    set_turn = 5;
    set_heading = 5;
    set_x = 32'h0;
    set_y = 32'h0;
    pen_x = 32'h0;
    pen_y = 32'h0;
    pen_heading = tgi_pkg::HEADING_RESET;
    depth = 0;

    // symbols before any begin act on the reset pose
    plan.push_back(sym_row(ACT_SYMBOL, SYM_FWD));
    plan.push_back(pin_row(ACT_SYMBOL, SYM_POP, tgi_pkg::KIND_UNDERFLOW, 32'h0, 32'h0));
    plan.push_back(pin_row(ACT_BEGIN, 8'h00, tgi_pkg::KIND_POINT, 32'h0, 32'h0));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_TURN_NEG));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_TURN_POS));
    plan.push_back(sym_row(ACT_SYMBOL, 8'h00));
    plan.push_back(sym_row(ACT_SYMBOL, 8'hFF));
    plan.push_back(sym_row(ACT_SYMBOL, 8'h66));
    plan.push_back(pin_row(ACT_BEGIN, 8'hFF, tgi_pkg::KIND_POINT, 32'h0, 32'h0));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_TURN_NEG));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_PUSH));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_FWD));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_POP));
    // fill the pose stack, overflow it, empty it, underflow it
    plan.push_back(sym_row(ACT_SYMBOL, SYM_PUSH, STACK_DEPTH));
    plan.push_back(pin_row(ACT_SYMBOL, SYM_PUSH, tgi_pkg::KIND_OVERFLOW, 32'h0, 32'h0));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_POP, STACK_DEPTH));
    plan.push_back(pin_row(ACT_SYMBOL, SYM_POP, tgi_pkg::KIND_UNDERFLOW, 32'h0, 32'h0));
    // start at the corners so that a step saturates both coordinates
    plan.push_back(cfg_row(tgi_pkg::CFG_TURN_STEP, 32'd71));
    plan.push_back(cfg_row(tgi_pkg::CFG_START_HEADING, 32'd71));
    plan.push_back(cfg_row(tgi_pkg::CFG_START_X, 32'h7FFF_FFFF));
    plan.push_back(cfg_row(tgi_pkg::CFG_START_Y, 32'h8000_0000));
    plan.push_back(pin_row(ACT_BEGIN, 8'h00, tgi_pkg::KIND_POINT,
                           32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(pin_row(ACT_SYMBOL, SYM_FWD, tgi_pkg::KIND_POINT,
                           32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_TURN_POS));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_FWD));
    // out-of-range angles wrap modulo 72
    plan.push_back(cfg_row(tgi_pkg::CFG_TURN_STEP, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(tgi_pkg::CFG_START_HEADING, 32'hFFFF_FF80));
    plan.push_back(cfg_row(tgi_pkg::CFG_START_X, 32'h8000_0000));
    plan.push_back(cfg_row(tgi_pkg::CFG_START_Y, 32'h7FFF_FFFF));
    plan.push_back(pin_row(ACT_BEGIN, 8'h00, tgi_pkg::KIND_POINT,
                           32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_FWD));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_TURN_NEG));
    plan.push_back(sym_row(ACT_SYMBOL, SYM_FWD));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        if (!settled) drain();
        write_cfg(plan[i].idx, plan[i].data, (i + 1 < plan.size()) && plan[i + 1].cfg);
      end else begin
        repeat (plan[i].reps)
          send_item(plan[i].act, plan[i].sym, plan[i].pinned, plan[i].pin);
      end
    end

    for (int p = 0; p < 5; p++) begin
      drain();
      idle_pct = 0;
      stall_pct = 0;
      write_cfg(tgi_pkg::CFG_TURN_STEP, pick_angle(), 1'b1);
      write_cfg(tgi_pkg::CFG_START_HEADING, pick_angle(), 1'b1);
      write_cfg(tgi_pkg::CFG_START_X, pick_coord(), 1'b1);
      write_cfg(tgi_pkg::CFG_START_Y, pick_coord(), 1'b0);
      idle_pct = send_idle[p];
      stall_pct = recv_stall[p];
      if (p == 4) begin
        // long output stall while items keep coming, so the input backs up
        @(posedge clk);
        hold_left = 120;
        @(negedge clk);
      end
      send_item(ACT_BEGIN, 8'($urandom_range(255)));
      sent = 1;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(999);
        if (r < 3) begin
          repeat (STACK_DEPTH + 2) send_item(ACT_SYMBOL, SYM_PUSH);
          sent += STACK_DEPTH + 2;
        end else if (r < 40) begin
          send_item(ACT_BEGIN, 8'($urandom_range(255)));
          sent++;
        end else if (r < 100) begin
          noise = 8'($urandom_range(255));
          send_item(ACT_SYMBOL, noise);
          sent++;
        end else begin
          if (r < 400)      send_item(ACT_SYMBOL, SYM_FWD);
          else if (r < 550) send_item(ACT_SYMBOL, SYM_TURN_NEG);
          else if (r < 700) send_item(ACT_SYMBOL, SYM_TURN_POS);
          else if (r < 850) send_item(ACT_SYMBOL, SYM_PUSH);
          else              send_item(ACT_SYMBOL, SYM_POP);
          sent++;
        end
      end
    end

    drain();
    if (mismatches == 0)
      $display("turtle_graphics_interpreter: match");
    else
      $display("turtle_graphics_interpreter: mismatch");
    $finish;
  end

endmodule
